@@ sv/quoted_printable_encoder_defines.svh @@
// ---------------------------------------------------------------------------
// Quoted-printable encoder assertion macros
// Shared assertion forms, clocked on clk and disabled while rst_n is low.
// ---------------------------------------------------------------------------
`ifndef QUOTED_PRINTABLE_ENCODER_DEFINES_SVH
`define QUOTED_PRINTABLE_ENCODER_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define QPE_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define QPE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ sv/qpe_pkg.sv @@
// ---------------------------------------------------------------------------
// Quoted-printable encoder package
// Character constants, the encoded group type and the hex digit function.
// ---------------------------------------------------------------------------
package qpe_pkg;

  localparam logic [7:0] CH_EQ    = 8'h3d;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0d;
  localparam logic [7:0] CH_LF    = 8'h0a;
  localparam logic [7:0] CH_SPACE = 8'h20;

  localparam logic [7:0] LINE_LIMIT_RST = 8'd72;
  localparam int         GRP_BYTES      = 6;

  // All output bytes caused by one input word, with the index of the last one.
  typedef struct packed {
    logic [GRP_BYTES-1:0][7:0] bytes;
    logic [2:0]                last_idx;
  } grp_t;

  function automatic logic [7:0] hex_digit(input logic [3:0] nib);
    logic [7:0] ext;
    ext = {4'h0, nib};
    if (nib < 4'd10) begin
      hex_digit = ext + 8'h30;
    end else begin
      hex_digit = ext + 8'h57;
    end
  endfunction

endpackage

@@ sv/qpe_encoder.sv @@
// ---------------------------------------------------------------------------
// Quoted-printable encoder front stage
// Encodes one input word into a group of output bytes and tracks line width.
// ---------------------------------------------------------------------------
module qpe_encoder (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          cfg_we,
  input  logic [7:0]    cfg_wdata,
  input  logic          in_tvalid,
  output logic          in_tready,
  input  logic [7:0]    in_tdata,
  input  logic          in_tlast,
  output logic          grp_valid,
  input  logic          grp_take,
  output qpe_pkg::grp_t grp
);

  logic [7:0]    limit_r;
  logic [8:0]    lw_r;
  logic [8:0]    lw_nxt;
  logic          pend_v_r;
  logic          pend_v_nxt;
  qpe_pkg::grp_t pend_r;
  qpe_pkg::grp_t pend_nxt;
  logic          accept;
  logic          esc;
  logic          brk;
  logic [8:0]    wsum;
  logic [2:0]    pos;

  assign in_tready = !pend_v_r || grp_take;
  assign accept    = in_tvalid && in_tready;
  assign grp_valid = pend_v_r;
  assign grp       = pend_r;

  always_comb begin
    esc  = in_tdata inside {qpe_pkg::CH_EQ, qpe_pkg::CH_TAB, qpe_pkg::CH_CR,
                            qpe_pkg::CH_LF, qpe_pkg::CH_SPACE};
    wsum = lw_r + (esc ? 9'd3 : 9'd1);
    brk  = wsum > {1'b0, limit_r};
    pend_nxt = '0;
    if (esc) begin
      pend_nxt.bytes[0] = qpe_pkg::CH_EQ;
      pend_nxt.bytes[1] = qpe_pkg::hex_digit(in_tdata[7:4]);
      pend_nxt.bytes[2] = qpe_pkg::hex_digit(in_tdata[3:0]);
      pos = 3'd3;
    end else begin
      pend_nxt.bytes[0] = in_tdata;
      pos = 3'd1;
    end
    if (brk) begin
      pend_nxt.bytes[pos]        = qpe_pkg::CH_EQ;
      pend_nxt.bytes[pos + 3'd1] = qpe_pkg::CH_LF;
      pos = pos + 3'd2;
    end
    if (in_tlast) begin
      pend_nxt.bytes[pos] = qpe_pkg::CH_EQ;
      pos = pos + 3'd1;
    end
    pend_nxt.last_idx = pos - 3'd1;
    lw_nxt = (brk || in_tlast) ? 9'd0 : wsum;
    if (accept) begin
      pend_v_nxt = 1'b1;
    end else if (grp_take) begin
      pend_v_nxt = 1'b0;
    end else begin
      pend_v_nxt = pend_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r  <= qpe_pkg::LINE_LIMIT_RST;
      lw_r     <= '0;
      pend_v_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        limit_r <= cfg_wdata;
      end
      if (accept) begin
        lw_r <= lw_nxt;
      end
      pend_v_r <= pend_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      pend_r <= pend_nxt;
    end
  end

endmodule

@@ sv/qpe_serializer.sv @@
// ---------------------------------------------------------------------------
// Quoted-printable encoder output stage
// Holds one encoded group and sends its bytes one word per cycle while out_tready is high.
// ---------------------------------------------------------------------------
module qpe_serializer (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          grp_valid,
  output logic          grp_take,
  input  qpe_pkg::grp_t grp,
  output logic          out_tvalid,
  input  logic          out_tready,
  output logic [7:0]    out_tdata,
  output logic          out_tlast
);

  qpe_pkg::grp_t cur_r;
  logic          vld_r;
  logic [2:0]    idx_r;
  logic [2:0]    idx_nxt;
  logic          fire;

  assign out_tvalid = vld_r;
  assign out_tdata  = cur_r.bytes[idx_r];
  assign out_tlast  = idx_r == cur_r.last_idx;
  assign fire       = vld_r && out_tready;
  assign grp_take   = !vld_r || (fire && out_tlast);

  always_comb begin
    if (grp_take) begin
      idx_nxt = '0;
    end else if (fire) begin
      idx_nxt = idx_r + 3'd1;
    end else begin
      idx_nxt = idx_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
      idx_r <= '0;
    end else begin
      if (grp_take) begin
        vld_r <= grp_valid;
      end
      idx_r <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (grp_take) begin
      cur_r <= grp;
    end
  end

endmodule

@@ sv/quoted_printable_encoder.sv @@
// ---------------------------------------------------------------------------
// Quoted-printable encoder
// Encodes a message byte stream into quoted-printable text with soft breaks.
// ---------------------------------------------------------------------------
// Each input word is encoded in the cycle it is accepted into a group of one
// to six output bytes, which then leave one word per cycle while out_tready
// is high; a group is registered in the encoder and then moved into the
// serializer's register, from which its first byte appears. The output port
// sets the rate: an item causes from one output byte for a plain byte up to
// six for an escaped final byte that also triggers a soft break. Input words
// are taken while a previous group drains, so no cycle of the output is lost
// between groups. The line limit may be written only while the encoder is idle.
module quoted_printable_encoder (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_we,
  input  logic [7:0] cfg_wdata,   // line_limit
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,    // [7:0] in_byte
  input  logic       in_tlast,    // final_byte
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,   // [7:0] out_byte
  output logic       out_tlast    // run_last
);

`include "quoted_printable_encoder_defines.svh"

  logic          grp_valid;
  logic          grp_take;
  qpe_pkg::grp_t grp;

  qpe_encoder u_enc (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .grp_valid (grp_valid),
    .grp_take  (grp_take),
    .grp       (grp)
  );

  qpe_serializer u_ser (
    .clk        (clk),
    .rst_n      (rst_n),
    .grp_valid  (grp_valid),
    .grp_take   (grp_take),
    .grp        (grp),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  `QPE_ASSERT_NEXT(a_group_continues, out_tvalid && out_tready && !out_tlast, out_tvalid, "group ended early")
  `QPE_ASSERT_SAME(a_no_overwrite, in_tvalid && in_tready, !grp_valid || grp_take, "pending group overwritten")
  `QPE_ASSERT_NEXT(a_group_loaded, grp_valid && grp_take, out_tvalid, "group not loaded")
  `QPE_ASSERT_SAME(a_last_in_range, out_tvalid, grp_take || !out_tready || !out_tlast, "take missed on last word")

endmodule

@@ tb/sv/tb_quoted_printable_encoder.sv @@
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// Quoted-printable encoder testbench
// Streams message bytes into the encoder under varying line limits and
// random stalls on both sides, predicts every encoded character with its
// own line-width model, and checks each output word in order.
// ---------------------------------------------------------------------------
module tb_quoted_printable_encoder;

  localparam int STALL_LIMIT  = 1000;
  localparam int DRAIN_CYCLES = 12;

  typedef enum logic [1:0] {OP_WORD, OP_LIMIT, OP_DRAIN} feed_op_t;

  typedef struct {
    feed_op_t   op;
    logic [7:0] data;
    logic       fin;
  } feed_t;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } qp_char_t;

  logic       clk        = 1'b0;
  logic       rst_n      = 1'b0;
  logic       cfg_we     = 1'b0;
  logic [7:0] cfg_wdata  = 8'd0;
  logic       in_tvalid  = 1'b0;
  logic       in_tready;
  logic [7:0] in_tdata   = 8'd0;
  logic       in_tlast   = 1'b0;
  logic       out_tvalid;
  logic       out_tready = 1'b0;
  logic [7:0] out_tdata;
  logic       out_tlast;

  feed_t      feed_q[$];
  qp_char_t   exp_chars[$];
  int         outstanding   = 0;
  int         send_idle_pct = 0;
  int         recv_idle_pct = 0;
  int         err_cnt       = 0;
  int         stall_cycles  = 0;
  logic [8:0] line_w;
  logic [7:0] lim_model;

  quoted_printable_encoder dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  function automatic logic [7:0] nibble_char(input logic [3:0] nib);
    if (nib <= 4'd9) begin
      return 8'h30 + {4'h0, nib};
    end
    return 8'h61 + {4'h0, nib} - 8'd10;
  endfunction

  function automatic void predict_encoding(input logic [7:0] b, input logic fin);
    qp_char_t grp[$];
    qp_char_t c;
    c.last = 1'b0;
    if (b == qpe_pkg::CH_EQ || b == qpe_pkg::CH_TAB || b == qpe_pkg::CH_CR ||
        b == qpe_pkg::CH_LF || b == qpe_pkg::CH_SPACE) begin
      c.ch = qpe_pkg::CH_EQ;
      grp.push_back(c);
      c.ch = nibble_char(b[7:4]);
      grp.push_back(c);
      c.ch = nibble_char(b[3:0]);
      grp.push_back(c);
      line_w = line_w + 9'd3;
    end else begin
      c.ch = b;
      grp.push_back(c);
      line_w = line_w + 9'd1;
    end
    if (line_w > {1'b0, lim_model}) begin
      c.ch = qpe_pkg::CH_EQ;
      grp.push_back(c);
      c.ch = qpe_pkg::CH_LF;
      grp.push_back(c);
      line_w = 9'd0;
    end
    if (fin) begin
      c.ch = qpe_pkg::CH_EQ;
      grp.push_back(c);
      line_w = 9'd0;
    end
    grp[grp.size() - 1].last = 1'b1;
    foreach (grp[i]) exp_chars.push_back(grp[i]);
  endfunction

  function automatic logic [7:0] rand_char();
    if ($urandom_range(9) < 3) begin
      case ($urandom_range(4))
        0: return qpe_pkg::CH_EQ;
        1: return qpe_pkg::CH_TAB;
        2: return qpe_pkg::CH_CR;
        3: return qpe_pkg::CH_LF;
        default: return qpe_pkg::CH_SPACE;
      endcase
    end
    return 8'($urandom_range(255));
  endfunction

  task automatic queue_byte(input logic [7:0] b, input logic fin);
    feed_t f;
    f.op = OP_WORD;
    f.data = b;
    f.fin = fin;
    feed_q.push_back(f);
  endtask

  task automatic queue_limit(input logic [7:0] v);
    feed_t f;
    f.op = OP_LIMIT;
    f.data = v;
    f.fin = 1'b0;
    feed_q.push_back(f);
  endtask

  task automatic queue_drain();
    feed_t f;
    f.op = OP_DRAIN;
    f.data = 8'd0;
    f.fin = 1'b0;
    feed_q.push_back(f);
  endtask

  // Most messages end with a final byte; about one in eight runs on into the next.
  task automatic queue_messages(input int total);
    int cnt;
    int len;
    bit ends;
    cnt = 0;
    while (cnt < total) begin
      len = $urandom_range(1, 24);
      ends = ($urandom_range(7) != 0);
      for (int i = 0; i < len; i++) begin
        queue_byte(rand_char(), ends && (i == len - 1));
      end
      cnt += len;
    end
  endtask

  task automatic wait_feed_empty();
    while (feed_q.size() != 0) @(posedge clk);
  endtask

  always @(posedge clk) begin
    feed_t      head;
    logic       v_n;
    logic [7:0] d_n;
    logic       l_n;
    logic       we_n;
    logic [7:0] wd_n;
    v_n  = in_tvalid;
    d_n  = in_tdata;
    l_n  = in_tlast;
    we_n = 1'b0;
    wd_n = cfg_wdata;
    if (!rst_n) begin
      v_n = 1'b0;
    end else if (!in_tvalid || in_tready) begin
      v_n = 1'b0;
      if (feed_q.size() != 0) begin
        head = feed_q[0];
        case (head.op)
          OP_WORD: begin
            if ($urandom_range(99) >= send_idle_pct) begin
              v_n = 1'b1;
              d_n = head.data;
              l_n = head.fin;
              void'(feed_q.pop_front());
            end
          end
          OP_LIMIT: begin
            if (!in_tvalid && outstanding == 0) begin
              we_n = 1'b1;
              wd_n = head.data;
              void'(feed_q.pop_front());
            end
          end
          default: begin
            if (!in_tvalid && outstanding == 0) begin
              void'(feed_q.pop_front());
            end
          end
        endcase
      end
    end
    in_tvalid <= v_n;
    in_tdata  <= d_n;
    in_tlast  <= l_n;
    cfg_we    <= we_n;
    cfg_wdata <= wd_n;
  end

  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    qp_char_t want;
    if (!rst_n) begin
      line_w    = 9'd0;
      lim_model = qpe_pkg::LINE_LIMIT_RST;
    end else begin
      if (cfg_we) begin
        lim_model = cfg_wdata;
      end
      if (out_tvalid && out_tready) begin
        if (exp_chars.size() == 0) begin
          err_cnt++;
          $display("%0t: unexpected word, expected none, actual byte %h last %b",
                   $time, out_tdata, out_tlast);
        end else begin
          want = exp_chars.pop_front();
          if (out_tdata !== want.ch || out_tlast !== want.last) begin
            err_cnt++;
            $display("%0t: mismatch, expected byte %h last %b, actual byte %h last %b",
                     $time, want.ch, want.last, out_tdata, out_tlast);
          end
        end
      end
      if (in_tvalid && in_tready) begin
        predict_encoding(in_tdata, in_tlast);
      end
    end
    outstanding <= exp_chars.size();
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_we) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles >= STALL_LIMIT) begin
      $display("%0t: no word moved for %0d cycles", $time, stall_cycles);
      $display("[quoted_printable_encoder] ERROR");
      $finish;
    end
  end

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    send_idle_pct = 25;
    recv_idle_pct = 45;

    // Reset limit: plain bytes, byte extremes, every escaped character.
    queue_byte(8'h41, 1'b0);
    queue_byte(8'h00, 1'b0);
    queue_byte(8'hff, 1'b0);
    queue_byte(qpe_pkg::CH_EQ, 1'b0);
    queue_byte(qpe_pkg::CH_TAB, 1'b0);
    queue_byte(qpe_pkg::CH_CR, 1'b0);
    queue_byte(qpe_pkg::CH_LF, 1'b0);
    queue_byte(qpe_pkg::CH_SPACE, 1'b1);
    queue_byte(8'h3c, 1'b0);
    queue_byte(8'h7e, 1'b1);
    // A limit of one breaks after the second plain byte and after every escape.
    queue_limit(8'd1);
    queue_byte(8'h78, 1'b0);
    queue_byte(8'h79, 1'b0);
    queue_byte(qpe_pkg::CH_SPACE, 1'b1);
    queue_byte(qpe_pkg::CH_EQ, 1'b0);
    queue_byte(qpe_pkg::CH_TAB, 1'b1);
    // A limit of zero breaks after every byte.
    queue_limit(8'd0);
    queue_byte(8'h61, 1'b0);
    queue_byte(qpe_pkg::CH_CR, 1'b0);
    queue_byte(8'h62, 1'b1);
    queue_byte(qpe_pkg::CH_LF, 1'b1);
    queue_drain();

    queue_limit(8'($urandom_range(2, 12)));
    queue_messages(45);
    queue_drain();
    queue_limit(qpe_pkg::LINE_LIMIT_RST);
    queue_messages(45);
    wait_feed_empty();

    send_idle_pct = 45;
    recv_idle_pct = 25;

    // Widest line: 85 escapes reach a width of 255 without a break, the next
    // escape takes it to 258.
    queue_limit(8'd255);
    queue_byte(8'h41, 1'b1);
    for (int i = 0; i < 86; i++) begin
      case ($urandom_range(4))
        0: queue_byte(qpe_pkg::CH_EQ, 1'b0);
        1: queue_byte(qpe_pkg::CH_TAB, 1'b0);
        2: queue_byte(qpe_pkg::CH_CR, 1'b0);
        3: queue_byte(qpe_pkg::CH_LF, 1'b0);
        default: queue_byte(qpe_pkg::CH_SPACE, 1'b0);
      endcase
    end
    queue_byte(8'h5a, 1'b1);
    queue_limit(8'($urandom_range(13, 100)));
    queue_messages(60);
    wait_feed_empty();

    send_idle_pct = 0;
    recv_idle_pct = 0;

    queue_limit(8'd1);
    queue_messages(30);
    queue_drain();
    queue_limit(8'd0);
    queue_messages(20);
    queue_limit(8'($urandom_range(1, 255)));
    queue_messages(40);

    while (feed_q.size() != 0 || in_tvalid || outstanding != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (exp_chars.size() != 0) begin
      err_cnt++;
      $display("%0t: %0d expected words never arrived, expected byte %h last %b, actual none",
               $time, exp_chars.size(), exp_chars[0].ch, exp_chars[0].last);
    end
    if (err_cnt == 0) begin
      $display("[quoted_printable_encoder] OK");
    end else begin
      $display("[quoted_printable_encoder] ERROR");
    end
    $finish;
  end

endmodule

@@ files.f @@
+incdir+sv
sv/qpe_pkg.sv
sv/qpe_encoder.sv
sv/qpe_serializer.sv
sv/quoted_printable_encoder.sv
tb/sv/tb_quoted_printable_encoder.sv
